// ----- sv/pfc_pkg.sv -----
`timescale 1ns / 1ps

package pfc_pkg;

    localparam int KEY_LEN    = 5;
    localparam int KEY_W      = 8 * KEY_LEN;
    localparam int LETTER_W   = 7;
    localparam int SQ_CELLS   = 25;
    localparam int SQ_LAST    = 4;

    localparam logic [KEY_W-1:0]    KEY_RESET   = 40'h4544434241;
    localparam logic [LETTER_W-1:0] ASCII_A     = 7'd65;
    localparam logic [LETTER_W-1:0] ASCII_J     = 7'd74;
    localparam logic [LETTER_W-1:0] ASCII_Z     = 7'd90;

    // status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_IN_SQ = 2'd1;
    localparam logic [1:0] ST_SAME      = 2'd2;
    localparam logic [1:0] ST_BAD_KEY   = 2'd3;

    // configuration register indexes
    localparam logic REG_KEY  = 1'b0;
    localparam logic REG_MODE = 1'b1;

    typedef logic [4:0] letter_idx_t;
    typedef letter_idx_t [KEY_LEN-1:0] key_idx_t;
    typedef logic [4:0] sq_pos_t;

    typedef struct packed {
        logic       in_sq;
        logic [2:0] row;
        logic [2:0] col;
    } lane_pos_t;

    typedef struct packed {
        logic [1:0]          status;
        sq_pos_t             tgt_a;
        sq_pos_t             tgt_b;
        logic [LETTER_W-1:0] letter_a;
        logic [LETTER_W-1:0] letter_b;
    } merge_out_t;

    function automatic logic in_square(input logic [LETTER_W-1:0] c);
        return (c >= ASCII_A) && (c <= ASCII_Z) && (c != ASCII_J);
    endfunction

    // index into the J-less alphabet
    function automatic letter_idx_t letter_idx(input logic [LETTER_W-1:0] c);
        logic [LETTER_W-1:0] off;
        off = c - ASCII_A;
        return off[4:0] - ((off > 7'd9) ? 5'd1 : 5'd0);
    endfunction

    function automatic logic [LETTER_W-1:0] idx_letter(input letter_idx_t idx);
        return ASCII_A + {2'b00, idx} + ((idx >= 5'd9) ? 7'd1 : 7'd0);
    endfunction

    function automatic key_idx_t key_indices(input logic [KEY_W-1:0] k);
        key_idx_t r;
        for (int i = 0; i < KEY_LEN; i++) begin
            r[i] = letter_idx(k[8*i +: LETTER_W]);
        end
        return r;
    endfunction

    function automatic logic key_check(input logic [KEY_W-1:0] k);
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < KEY_LEN; i++) begin
            if (k[8*i+7] || !in_square(k[8*i +: LETTER_W])) begin
                ok = 1'b0;
            end
            for (int j = 0; j < i; j++) begin
                if (k[8*j +: 8] == k[8*i +: 8]) begin
                    ok = 1'b0;
                end
            end
        end
        return ok;
    endfunction

    // number of key letters that sort before the given letter
    function automatic logic [2:0] count_below(input key_idx_t ki, input letter_idx_t idx);
        logic [2:0] n;
        n = 3'd0;
        for (int j = 0; j < KEY_LEN; j++) begin
            if (ki[j] < idx) begin
                n = n + 3'd1;
            end
        end
        return n;
    endfunction

    function automatic logic [2:0] step_pos(input logic [2:0] v, input logic back);
        if (back) begin
            return (v == 3'd0) ? 3'(SQ_LAST) : v - 3'd1;
        end
        return (v == 3'(SQ_LAST)) ? 3'd0 : v + 3'd1;
    endfunction

endpackage

// ----- sv/pfc_lane.sv -----
`timescale 1ns / 1ps

module pfc_lane (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [pfc_pkg::LETTER_W-1:0] letter,
    input  pfc_pkg::key_idx_t            key_idx,
    output pfc_pkg::lane_pos_t           pos_reg
);
    import pfc_pkg::*;

    letter_idx_t idx;
    logic        hit;
    sq_pos_t     hit_pos;
    sq_pos_t     pos;
    logic [2:0]  row;
    lane_pos_t   pos_next;

    always_comb begin
        idx     = letter_idx(letter);
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = 0; i < KEY_LEN; i++) begin
            if (key_idx[i] == idx) begin
                hit     = 1'b1;
                hit_pos = 5'(i);
            end
        end
        // letters outside the key follow it in alphabet order
        pos = hit ? hit_pos : 5'd5 + idx - {2'b00, count_below(key_idx, idx)};
        if (pos >= 5'd20) begin
            row = 3'd4;
        end else if (pos >= 5'd15) begin
            row = 3'd3;
        end else if (pos >= 5'd10) begin
            row = 3'd2;
        end else if (pos >= 5'd5) begin
            row = 3'd1;
        end else begin
            row = 3'd0;
        end
        pos_next.in_sq = in_square(letter);
        pos_next.row   = row;
        pos_next.col   = 3'(pos - {row, 2'b00} - {2'b00, row});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pos_reg <= pos_next;
        end
    end

endmodule

// ----- sv/pfc_merge.sv -----
`timescale 1ns / 1ps

module pfc_merge (
    input  logic                         aclk,
    input  logic                         en,
    input  logic                         decrypt,
    input  logic                         key_ok,
    input  logic [pfc_pkg::LETTER_W-1:0] letter_a,
    input  logic [pfc_pkg::LETTER_W-1:0] letter_b,
    input  pfc_pkg::lane_pos_t           pos_a,
    input  pfc_pkg::lane_pos_t           pos_b,
    output pfc_pkg::merge_out_t          mo_reg
);
    import pfc_pkg::*;

    logic [2:0] ra, ca, rb, cb;
    merge_out_t mo_next;

    always_comb begin
        ra = pos_a.row;
        ca = pos_a.col;
        rb = pos_b.row;
        cb = pos_b.col;
        if (pos_a.row == pos_b.row) begin
            ca = step_pos(pos_a.col, decrypt);
            cb = step_pos(pos_b.col, decrypt);
        end else if (pos_a.col == pos_b.col) begin
            ra = step_pos(pos_a.row, decrypt);
            rb = step_pos(pos_b.row, decrypt);
        end else begin
            ca = pos_b.col;
            cb = pos_a.col;
        end

        if (!key_ok) begin
            mo_next.status = ST_BAD_KEY;
        end else if (!pos_a.in_sq || !pos_b.in_sq) begin
            mo_next.status = ST_NOT_IN_SQ;
        end else if (letter_a == letter_b) begin
            mo_next.status = ST_SAME;
        end else begin
            mo_next.status = ST_OK;
        end
        mo_next.tgt_a    = {ra[2:0], 2'b00} + {2'b00, ra} + {2'b00, ca};
        mo_next.tgt_b    = {rb[2:0], 2'b00} + {2'b00, rb} + {2'b00, cb};
        mo_next.letter_a = letter_a;
        mo_next.letter_b = letter_b;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mo_reg <= mo_next;
        end
    end

endmodule

// ----- sv/pfc_decode.sv -----
`timescale 1ns / 1ps

module pfc_decode (
    input  pfc_pkg::sq_pos_t             pos,
    input  pfc_pkg::key_idx_t            key_idx,
    output logic [pfc_pkg::LETTER_W-1:0] letter
);
    import pfc_pkg::*;

    letter_idx_t idx;
    letter_idx_t found;
    sq_pos_t     rank;
    logic        is_key;

    always_comb begin
        rank  = pos - 5'd5;
        found = '0;
        // the rank-th letter of the alphabet not used by the key
        for (int l = 0; l < SQ_CELLS; l++) begin
            is_key = 1'b0;
            for (int j = 0; j < KEY_LEN; j++) begin
                if (key_idx[j] == 5'(l)) begin
                    is_key = 1'b1;
                end
            end
            if (!is_key && (5'(l) - {2'b00, count_below(key_idx, 5'(l))} == rank)) begin
                found = found | 5'(l);
            end
        end
        idx    = (pos < 5'd5) ? key_idx[pos[2:0]] : found;
        letter = idx_letter(idx);
    end

endmodule

// ----- sv/playfair_digraph_cipher.sv -----
`timescale 1ns / 1ps

// Playfair cipher engine, one letter pair per word. The 5x5 square comes from the
// five-letter key in register 0 (first letter in the low byte), and register 1
// picks encryption (0) or decryption (1). Two locate lanes find the row and column
// of each letter, a merge stage applies the same-row, same-column or rectangle rule,
// and the output stage maps the new positions back to letters. A new pair is taken
// every cycle while the output is not stalled by m_ready. There is one register each
// in the locate, merge and output stages, which a pair passes through in that order
// before its result is presented with m_valid. Status 3 flags a bad key, 1 a J or
// a non-letter, 2 a doubled letter; in those cases the letters pass unchanged.
// Write the registers only while no pair is in flight.
module playfair_digraph_cipher (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_index,
    input  logic [pfc_pkg::KEY_W-1:0]    cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [pfc_pkg::LETTER_W-1:0] s_first_letter,
    input  logic [pfc_pkg::LETTER_W-1:0] s_second_letter,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [pfc_pkg::LETTER_W-1:0] m_out_first,
    output logic [pfc_pkg::LETTER_W-1:0] m_out_second,
    output logic [1:0]                   m_status
);
    import pfc_pkg::*;

    key_idx_t            key_idx_reg;
    logic                key_ok_reg;
    logic                decrypt_reg;

    logic                v1_reg, v2_reg, v3_reg;
    logic                rdy1, rdy2, rdy3;
    logic [LETTER_W-1:0] a1_reg, b1_reg;
    lane_pos_t           pos_a, pos_b;
    merge_out_t          mo;
    logic [LETTER_W-1:0] dec_a, dec_b;
    logic [LETTER_W-1:0] first_reg, second_reg;
    logic [1:0]          status_reg;

    assign cfg_ready = 1'b1;

    // key is checked and indexed as it is written
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_idx_reg <= key_indices(KEY_RESET);
            key_ok_reg  <= key_check(KEY_RESET);
            decrypt_reg <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_KEY: begin
                    key_idx_reg <= key_indices(cfg_data);
                    key_ok_reg  <= key_check(cfg_data);
                end
                REG_MODE: begin
                    decrypt_reg <= cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    assign rdy3    = !v3_reg || m_ready;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= s_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            a1_reg <= s_first_letter;
            b1_reg <= s_second_letter;
        end
    end

    pfc_lane u_lane_a (
        .aclk    (aclk),
        .en      (rdy1),
        .letter  (s_first_letter),
        .key_idx (key_idx_reg),
        .pos_reg (pos_a)
    );

    pfc_lane u_lane_b (
        .aclk    (aclk),
        .en      (rdy1),
        .letter  (s_second_letter),
        .key_idx (key_idx_reg),
        .pos_reg (pos_b)
    );

    pfc_merge u_merge (
        .aclk     (aclk),
        .en       (rdy2),
        .decrypt  (decrypt_reg),
        .key_ok   (key_ok_reg),
        .letter_a (a1_reg),
        .letter_b (b1_reg),
        .pos_a    (pos_a),
        .pos_b    (pos_b),
        .mo_reg   (mo)
    );

    pfc_decode u_dec_a (
        .pos     (mo.tgt_a),
        .key_idx (key_idx_reg),
        .letter  (dec_a)
    );

    pfc_decode u_dec_b (
        .pos     (mo.tgt_b),
        .key_idx (key_idx_reg),
        .letter  (dec_b)
    );

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            first_reg  <= (mo.status == ST_OK) ? dec_a : mo.letter_a;
            second_reg <= (mo.status == ST_OK) ? dec_b : mo.letter_b;
            status_reg <= mo.status;
        end
    end

    assign m_valid      = v3_reg;
    assign m_out_first  = first_reg;
    assign m_out_second = second_reg;
    assign m_status     = status_reg;

    // a bad key always shows up as the key status
    a_bad_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !key_ok_reg |-> m_status == ST_BAD_KEY)
        else $error("bad key not reported");

    a_good_key: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && key_ok_reg |-> m_status != ST_BAD_KEY)
        else $error("valid key reported as bad");

    // distinct square cells always map to distinct cells
    a_distinct: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK |-> m_out_first != m_out_second)
        else $error("cipher pair collapsed");

    a_no_j: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_OK |-> m_out_first != ASCII_J && m_out_second != ASCII_J)
        else $error("letter outside square produced");

    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg)
        else $error("accepted word lost at locate stage");

endmodule
